### hdl/dq_pkg.sv
// Shared types and constants of the double-ended queue.
package dq_pkg;

	localparam int WORD_W = 32;
	localparam int CMD_W = 3;
	localparam int STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	typedef logic [CMD_W-1:0] cmd_code_t;
	typedef logic [STAT_W-1:0] stat_code_t;
	typedef logic signed [WORD_W-1:0] word_t;

	typedef struct packed {
		logic load;
		logic deliver;
	} dq_cmd_t;

endpackage

### hdl/dq_if.sv
// Handshake channels for command and result transactions.
interface dq_req_if;
	import dq_pkg::*;
	logic valid;
	logic ready;
	cmd_code_t command;
	word_t value;
	modport source(output valid, output command, output value, input ready);
	modport sink(input valid, input command, input value, output ready);
endinterface

interface dq_rsp_if #(parameter int CNT_W = 9);
	import dq_pkg::*;
	logic valid;
	logic ready;
	word_t popped;
	stat_code_t status;
	logic [CNT_W-1:0] occupancy;
	modport source(output valid, output popped, output status, output occupancy, input ready);
	modport sink(input valid, input popped, input status, input occupancy, output ready);
endinterface

### hdl/dq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### hdl/dq_ctrl.sv
// Controller state machine that sequences command and result transactions.
module dq_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input logic rsp_ready,
	output dq_pkg::dq_cmd_t cmd
);
	import dq_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DONE = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_DONE);
	assign cmd.load = req_valid && req_ready;
	assign cmd.deliver = rsp_valid && rsp_ready;

`ifndef NO_ASSERTIONS
	a_load_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> rsp_valid)
		else $error("A command transaction did not produce a result.");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_ready && rsp_valid))
		else $error("A command was offered while a result was pending.");
	a_deliver_frees: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deliver |=> req_ready)
		else $error("The controller did not return to idle after a result.");
`endif
endmodule

### hdl/dq_dp.sv
// Datapath with the front pointer, the count, the slot storage and the result registers.
module dq_dp #(
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	input dq_pkg::dq_cmd_t cmd,
	input dq_pkg::cmd_code_t command,
	input dq_pkg::word_t value,
	output dq_pkg::word_t popped,
	output dq_pkg::stat_code_t status,
	output logic [$clog2(DEPTH+1)-1:0] occupancy
);
	import dq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	stat_code_t status_q;
	logic popsel_q;

	logic full;
	logic empty;
	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;
	logic [SUM_W-1:0] back_sum;
	logic [SUM_W-1:0] last_sum;
	logic [IDX_W-1:0] tail_idx;
	logic [IDX_W-1:0] last_idx;

	logic we;
	logic re;
	logic [IDX_W-1:0] waddr;
	logic [IDX_W-1:0] raddr;
	logic [WORD_W-1:0] rdata;
	logic [IDX_W-1:0] front_d;
	logic [CNT_W-1:0] count_d;
	stat_code_t status_d;
	logic popsel_d;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign back_sum = SUM_W'(count_q) + SUM_W'(front_q);
	assign last_sum = back_sum - 1'b1;
	assign tail_idx = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
		: IDX_W'(back_sum);
	assign last_idx = (last_sum >= SUM_W'(DEPTH)) ? IDX_W'(last_sum - SUM_W'(DEPTH))
		: IDX_W'(last_sum);

	always_comb begin
		we = 1'b0;
		re = 1'b0;
		waddr = front_dec;
		raddr = front_q;
		front_d = front_q;
		count_d = count_q;
		status_d = STAT_OK;
		popsel_d = 1'b0;
		unique case (command)
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					we = 1'b1;
					waddr = front_dec;
					front_d = front_dec;
					count_d = count_q + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					we = 1'b1;
					waddr = tail_idx;
					count_d = count_q + 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					re = 1'b1;
					raddr = front_q;
					popsel_d = 1'b1;
					front_d = front_inc;
					count_d = count_q - 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					re = 1'b1;
					raddr = last_idx;
					popsel_d = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			CMD_CLEAR: begin
				front_d = '0;
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (cmd.load) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= status_d;
			popsel_q <= popsel_d;
		end
	end

	dq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(we && cmd.load),
		.waddr(waddr),
		.wdata(value),
		.re(re && cmd.load),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign popped = popsel_q ? word_t'(rdata) : '0;
	assign status = status_q;
	assign occupancy = count_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("The stored count exceeds the depth.");
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && command == CMD_CLEAR |=> count_q == '0 && front_q == '0)
		else $error("A clear did not empty the deque.");
	a_pop_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && empty && (command == CMD_POP_FRONT || command == CMD_POP_BACK)
		|=> status_q == STAT_EMPTY && empty)
		else $error("A pop on an empty deque was not flagged.");
`endif
endmodule

### hdl/double_ended_queue_core.sv
// Top level of the double-ended queue of signed words in a circular buffer.
// The result transaction is offered in the cycle after the command is taken.
// A new command is taken only once the single-entry result register has been emptied.
// Reset clears the front pointer and the count; slot contents are not cleared.
module double_ended_queue_core #(
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	dq_req_if.sink req,
	dq_rsp_if.source rsp
);
	import dq_pkg::*;

	dq_cmd_t cmd;

	dq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.rsp_valid(rsp.valid),
		.rsp_ready(rsp.ready),
		.cmd(cmd)
	);

	dq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.command(req.command),
		.value(req.value),
		.popped(rsp.popped),
		.status(rsp.status),
		.occupancy(rsp.occupancy)
	);
endmodule

### tb/double_ended_queue_core_tb.sv
// Self-checking testbench of the double-ended queue core with random handshake stalls.
module double_ended_queue_core_tb;
	import dq_pkg::*;

	localparam int DEPTH = 256;
	localparam int CNT_W = 9;
	localparam int CYCLE_LIMIT = 200000;
	localparam cmd_code_t FIRST_UNUSED_CMD = CMD_CLEAR + 3'd1;
	localparam cmd_code_t LAST_UNUSED_CMD = {CMD_W{1'b1}};
	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	typedef struct {
		word_t popped;
		stat_code_t status;
		logic [CNT_W-1:0] occupancy;
	} deque_result_t;

	class deque_scoreboard;
		word_t slot_words[DEPTH];
		int unsigned head_slot;
		int unsigned word_total;
		deque_result_t awaited_results[$];
		int unsigned mismatches;

		function new();
			head_slot = 0;
			word_total = 0;
			mismatches = 0;
		endfunction

		function void note_command(cmd_code_t cmd, word_t value);
			deque_result_t res;
			res.popped = '0;
			res.status = STAT_OK;
			case (cmd)
				CMD_PUSH_FRONT: begin
					if (word_total >= DEPTH) begin
						res.status = STAT_FULL;
					end else begin
						head_slot = (head_slot + DEPTH - 1) % DEPTH;
						slot_words[head_slot] = value;
						word_total++;
					end
				end
				CMD_PUSH_BACK: begin
					if (word_total >= DEPTH) begin
						res.status = STAT_FULL;
					end else begin
						slot_words[(head_slot + word_total) % DEPTH] = value;
						word_total++;
					end
				end
				CMD_POP_FRONT: begin
					if (word_total == 0) begin
						res.status = STAT_EMPTY;
					end else begin
						res.popped = slot_words[head_slot];
						head_slot = (head_slot + 1) % DEPTH;
						word_total--;
					end
				end
				CMD_POP_BACK: begin
					if (word_total == 0) begin
						res.status = STAT_EMPTY;
					end else begin
						res.popped = slot_words[(head_slot + word_total - 1) % DEPTH];
						word_total--;
					end
				end
				CMD_CLEAR: begin
					head_slot = 0;
					word_total = 0;
				end
				default: begin
				end
			endcase
			res.occupancy = CNT_W'(word_total);
			awaited_results.push_back(res);
		endfunction

		function void check_result(word_t popped, stat_code_t status,
				logic [CNT_W-1:0] occupancy);
			deque_result_t res;
			if (awaited_results.size() == 0) begin
				$error("unexpected result transaction: popped %0d status %0d occupancy %0d",
					popped, status, occupancy);
				mismatches++;
				return;
			end
			res = awaited_results.pop_front();
			if (popped !== res.popped) begin
				$error("popped: expected %0d, actual %0d", res.popped, popped);
				mismatches++;
			end
			if (status !== res.status) begin
				$error("status: expected %0d, actual %0d", res.status, status);
				mismatches++;
			end
			if (occupancy !== res.occupancy) begin
				$error("occupancy: expected %0d, actual %0d", res.occupancy, occupancy);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return awaited_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit steady_stretch;
	int unsigned cycle_count;
	deque_scoreboard sb;

	dq_req_if req_ch();
	dq_rsp_if #(.CNT_W(CNT_W)) rsp_ch();

	double_ended_queue_core #(.DEPTH(DEPTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic word_t random_word();
		case ($urandom_range(19))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return '0;
			3: return '1;
			default: return word_t'($urandom);
		endcase
	endfunction

	task automatic send_command(cmd_code_t cmd, word_t value);
		while (!steady_stretch && $urandom_range(99) < 7) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.value <= value;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_command(cmd, value);
	endtask

	task automatic hold_until_drained();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.outstanding() != 0);
	endtask

	task automatic burst(bit pushing, int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			if (pushing)
				send_command($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, random_word());
			else
				send_command($urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT, random_word());
		end
	endtask

	task automatic mixed_traffic(int unsigned count);
		int unsigned push_bias;
		int unsigned roll;
		cmd_code_t cmd;
		push_bias = 50;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 60 == 0)
				push_bias = $urandom_range(20, 80);
			roll = $urandom_range(99);
			if (roll < 2)
				cmd = CMD_CLEAR;
			else if (roll < 5)
				cmd = cmd_code_t'($urandom_range(FIRST_UNUSED_CMD, LAST_UNUSED_CMD));
			else if ($urandom_range(99) < push_bias)
				cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
			else
				cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
			send_command(cmd, random_word());
		end
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_result(rsp_ch.popped, rsp_ch.status, rsp_ch.occupancy);
			rsp_ch.ready <= steady_stretch || $urandom_range(99) >= 7;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		sb = new();
		steady_stretch = 1'b0;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.command <= CMD_PUSH_FRONT;
		req_ch.value <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(CMD_POP_FRONT, '0);
		send_command(CMD_POP_BACK, '1);
		send_command(CMD_CLEAR, WORD_MAX);
		send_command(CMD_PUSH_BACK, WORD_MAX);
		send_command(CMD_PUSH_FRONT, WORD_MIN);
		send_command(CMD_PUSH_BACK, '1);
		send_command(CMD_PUSH_FRONT, '0);
		send_command(CMD_POP_FRONT, WORD_MIN);
		send_command(CMD_POP_BACK, '0);
		for (int c = FIRST_UNUSED_CMD; c <= LAST_UNUSED_CMD; c++)
			send_command(cmd_code_t'(c), '1);
		send_command(CMD_POP_FRONT, '0);
		send_command(CMD_POP_BACK, '0);
		send_command(CMD_POP_BACK, '0);
		send_command(CMD_PUSH_FRONT, 32'sh5555_5555);
		send_command(CMD_POP_BACK, '0);
		send_command(CMD_PUSH_FRONT, 32'sh5555_5555);
		send_command(CMD_PUSH_BACK, 32'shAAAA_AAAA);
		send_command(CMD_CLEAR, '0);
		send_command(CMD_POP_FRONT, '0);

		mixed_traffic(200);
		burst(1'b1, 262);
		hold_until_drained();
		steady_stretch = 1'b1;
		burst(1'b0, 150);
		steady_stretch = 1'b0;
		burst(1'b0, 112);
		mixed_traffic(200);

		hold_until_drained();
		repeat (4) @(posedge clk);
		if (sb.mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
